/* rtl/baro_compensation_sequencer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation sequencer
// Shared property forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef BARO_COMPENSATION_SEQUENCER_TOP_DEFINES_SVH
`define BARO_COMPENSATION_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define BCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcs: same-cycle property failed");

// next-cycle implication
`define BCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcs: next-cycle property failed");

`endif

/* rtl/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// bcs_pkg
// Microcode control word, program table and constants of the sequencer.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int RAW_W    = 24;
  localparam int CAL_W    = 16;
  localparam int LEN_W    = 5;
  localparam int POS_W    = 4;
  localparam int DT_W     = 25;
  localparam int MA_W     = 25;
  localparam int MB_W     = 18;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int OS_W     = 35;
  localparam int ACC_W    = 59;
  localparam int TEMP_W   = 24;
  localparam int PRESS_W  = 28;
  localparam int PC_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0] CYCLE_MIN = 5'd2;
  localparam logic [LEN_W-1:0] CYCLE_MAX = 5'd16;
  localparam logic [LEN_W-1:0] CYCLE_RST = 5'd5;
  localparam logic signed [DT_W-1:0] TEMP_BASE = 25'sd64000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PSENS   = 3'd0,
    REG_POFF    = 3'd1,
    REG_STC     = 3'd2,
    REG_OTC     = 3'd3,
    REG_TREF    = 3'd4,
    REG_TSENS   = 3'd5,
    REG_CYC_LEN = 3'd6
  } cfg_reg_t;

  typedef enum logic {MA_DT, MA_RAW} mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_TSENS, MB_OTC, MB_STC, MB_SLO, MB_SHI
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_DT, OP_TEMP, OP_OFF, OP_SENS, OP_ACC_LD, OP_ACC_ADD, OP_PRESS
  } op_t;

  typedef enum logic [1:0] {BR_NEXT, BR_PRESS, BR_END} branch_t;

  typedef struct packed {
    mul_a_sel_t       mul_a;
    mul_b_sel_t       mul_b;
    op_t              op;
    branch_t          br;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd0;
  localparam logic [PC_W-1:0] PC_T_DT     = 4'd1;
  localparam logic [PC_W-1:0] PC_T_MUL    = 4'd2;
  localparam logic [PC_W-1:0] PC_T_OUT    = 4'd3;
  localparam logic [PC_W-1:0] PC_P_MOFF   = 4'd4;
  localparam logic [PC_W-1:0] PC_P_OFF    = 4'd5;
  localparam logic [PC_W-1:0] PC_P_SENS   = 4'd6;
  localparam logic [PC_W-1:0] PC_P_MLO    = 4'd7;
  localparam logic [PC_W-1:0] PC_P_ACC    = 4'd8;
  localparam logic [PC_W-1:0] PC_P_ADD    = 4'd9;
  localparam logic [PC_W-1:0] PC_P_OUT    = 4'd10;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{mul_a: MA_DT, mul_b: MB_TSENS, op: OP_NOP, br: BR_NEXT, target: PC_DISPATCH};
    case (pc)
      PC_DISPATCH: begin
        w.br = BR_PRESS;
        w.target = PC_P_MOFF;
      end
      PC_T_DT:  w.op = OP_DT;
      PC_T_MUL: w.mul_b = MB_TSENS;
      PC_T_OUT: begin
        w.op = OP_TEMP;
        w.br = BR_END;
      end
      PC_P_MOFF: w.mul_b = MB_OTC;
      PC_P_OFF: begin
        w.op = OP_OFF;
        w.mul_b = MB_STC;
      end
      PC_P_SENS: w.op = OP_SENS;
      PC_P_MLO: begin
        w.mul_a = MA_RAW;
        w.mul_b = MB_SLO;
      end
      PC_P_ACC: begin
        w.op = OP_ACC_LD;
        w.mul_a = MA_RAW;
        w.mul_b = MB_SHI;
      end
      PC_P_ADD: begin
        w.op = OP_ACC_ADD;
        w.mul_a = MA_RAW;
        w.mul_b = MB_SHI;
      end
      PC_P_OUT: begin
        w.op = OP_PRESS;
        w.br = BR_END;
      end
      default: w.br = BR_END;
    endcase
    return w;
  endfunction

endpackage

/* rtl/baro_compensation_sequencer_top.sv */
// ----------------------------------------------------------------------------
// baro_compensation_sequencer_top
// First-order barometric compensation run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Each input beat is one 24-bit raw conversion; readings_per_cycle beats
// (clamped to 2..16) form a cycle of one temperature reading followed by
// pressure readings. One result beat leaves per input beat, and a new beat
// is taken only once the last one's program has ended. The program steps one
// control word per cycle, holding at its last word until the output register
// is free, through a single shared 25x18 signed multiplier; the 59-bit
// raw*SENS product takes two passes through it. The next beat is taken as soon
// as the program ends, even while the result still waits in the output register.
module baro_compensation_sequencer_top
  import bcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [RAW_W-1:0]     s_tdata,   // [23:0] raw_sample
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // [23:0] temperature, [51:24] pressure,
                                          // [52] next_is_temperature
  output logic                 m_tuser    // [0] is_pressure
);

  logic [CAL_W-1:0] cal_pressure_sens, cal_pressure_offset, cal_sens_temp_coef;
  logic [CAL_W-1:0] cal_offset_temp_coef, cal_reference_temp, cal_temp_sens;
  logic [LEN_W-1:0] readings_per_cycle;

  logic [POS_W-1:0]         pos, pos_next;
  logic [LEN_W-1:0]         len, pos_inc;
  logic                     busy, is_press, next_temp;
  logic [PC_W-1:0]          pc;
  logic [RAW_W-1:0]         raw;
  logic signed [DT_W-1:0]   dt;
  logic signed [PROD_W-1:0] prod;
  logic signed [OS_W-1:0]   off, sens;
  logic signed [ACC_W-1:0]  acc;

  ctrl_word_t               cw;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [DT_W-1:0]   dt_calc, temp_sum;
  logic signed [OS_W-1:0]   off_calc, sens_calc;
  logic signed [38:0]       press_diff;
  logic [TEMP_W-1:0]        temp_val;
  logic [PRESS_W-1:0]       press_val;
  logic                     s_beat, out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign s_beat    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cw        = ucode_rom(pc);

  always_comb begin
    if (readings_per_cycle < CYCLE_MIN) begin
      len = CYCLE_MIN;
    end else if (readings_per_cycle > CYCLE_MAX) begin
      len = CYCLE_MAX;
    end else begin
      len = readings_per_cycle;
    end
    pos_inc  = (pos == '0) ? LEN_W'(1) : LEN_W'(pos) + LEN_W'(1);
    pos_next = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
  end

  always_comb begin
    case (cw.mul_a)
      MA_DT:   mul_a = dt;
      MA_RAW:  mul_a = $signed({1'b0, raw});
      default: mul_a = dt;
    endcase
    case (cw.mul_b)
      MB_TSENS: mul_b = $signed({2'b0, cal_temp_sens});
      MB_OTC:   mul_b = $signed({2'b0, cal_offset_temp_coef});
      MB_STC:   mul_b = $signed({2'b0, cal_sens_temp_coef});
      MB_SLO:   mul_b = $signed({1'b0, sens[16:0]});
      MB_SHI:   mul_b = sens[OS_W-1:17];
      default:  mul_b = '0;
    endcase
  end

  always_comb begin
    dt_calc = (raw == '0) ? '0
            : $signed({1'b0, raw}) - $signed({1'b0, cal_reference_temp, 8'b0});
    off_calc  = $signed({3'b0, cal_pressure_offset, 16'b0}) + OS_W'(prod >>> 7);
    sens_calc = $signed({4'b0, cal_pressure_sens, 15'b0}) + OS_W'(prod >>> 8);
    temp_sum  = DT_W'(prod >>> 18) + TEMP_BASE;
    temp_val  = (dt == '0) ? '0 : temp_sum[TEMP_W-1:0];
    press_diff = 39'(acc >>> 21) - 39'(off);
    press_val  = (raw == '0 || dt == '0) ? '0 : press_diff[37:10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_pressure_sens    <= '0;
      cal_pressure_offset  <= '0;
      cal_sens_temp_coef   <= '0;
      cal_offset_temp_coef <= '0;
      cal_reference_temp   <= '0;
      cal_temp_sens        <= '0;
      readings_per_cycle   <= CYCLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PSENS:   cal_pressure_sens    <= cfg_data;
        REG_POFF:    cal_pressure_offset  <= cfg_data;
        REG_STC:     cal_sens_temp_coef   <= cfg_data;
        REG_OTC:     cal_offset_temp_coef <= cfg_data;
        REG_TREF:    cal_reference_temp   <= cfg_data;
        REG_TSENS:   cal_temp_sens        <= cfg_data;
        REG_CYC_LEN: readings_per_cycle   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= PC_DISPATCH;
      pos       <= '0;
      dt        <= '0;
      is_press  <= 1'b0;
      next_temp <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_beat) begin
        busy      <= 1'b1;
        pc        <= PC_DISPATCH;
        is_press  <= (pos != '0);
        pos       <= pos_next;
        next_temp <= (pos_next == '0);
      end else if (busy) begin
        if (cw.op == OP_DT) begin
          dt <= dt_calc;
        end
        case (cw.br)
          BR_NEXT:  pc <= pc + PC_W'(1);
          BR_PRESS: pc <= is_press ? cw.target : pc + PC_W'(1);
          BR_END: begin
            if (out_free) begin
              busy     <= 1'b0;
              m_tvalid <= 1'b1;
            end
          end
          default: pc <= pc;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (s_beat) begin
      raw <= s_tdata;
    end
    if (busy) begin
      case (cw.op)
        OP_OFF:     off  <= off_calc;
        OP_SENS:    sens <= sens_calc;
        OP_ACC_LD:  acc  <= ACC_W'(prod);
        OP_ACC_ADD: acc  <= acc + (ACC_W'(prod) <<< 17);
        default: ;
      endcase
      if (cw.br == BR_END && out_free) begin
        m_tuser <= is_press;
        if (cw.op == OP_PRESS) begin
          m_tdata <= {3'b0, next_temp, press_val, {TEMP_W{1'b0}}};
        end else begin
          m_tdata <= {3'b0, next_temp, {PRESS_W{1'b0}}, temp_val};
        end
      end
    end
  end

endmodule

/* rtl/bcs_checker.sv */
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks of the compensation sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "baro_compensation_sequencer_top_defines.svh"

module bcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);

  `BCS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BCS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  `BCS_ASSERT_SAME(a_temp_no_press, m_tvalid && !m_tuser, m_tdata[51:24] == 28'd0)
  `BCS_ASSERT_SAME(a_press_no_temp, m_tvalid && m_tuser, m_tdata[23:0] == 24'd0)

endmodule

bind baro_compensation_sequencer_top bcs_checker u_bcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
